// ----- hdl/tpm_pkg.sv -----
// shared types, codes and reset values of the thermal and memory pressure monitor
`default_nettype none

package tpm_pkg;

   // field widths
   localparam int TEMP_W  = 8;
   localparam int BYTES_W = 48;
   localparam int ACT_W   = 3;
   localparam int CSR_IDX_W = 3;

   // up to this many results per item
   localparam int MAX_ACTS = 3;
   localparam int CNT_W    = 2;

   // result queue: four entries, so an item may enter while at most one entry is used
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // action codes
   localparam logic [ACT_W-1:0] ACT_WARN        = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UNLOAD      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CRITICAL    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RECOVERED   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_GAMING_TRIM = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FLOOR_TRIM  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOAD_TEMP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_TEMP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_TEMP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMING_ENABLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMING_MIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_ENABLE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_MIN      = 3'd7;

   // register reset values
   localparam logic [TEMP_W-1:0] RST_CRITICAL_TEMP = 8'd95;
   localparam logic [TEMP_W-1:0] RST_UNLOAD_TEMP   = 8'd90;
   localparam logic [TEMP_W-1:0] RST_WARN_TEMP     = 8'd85;
   localparam logic [TEMP_W-1:0] RST_RECOVER_TEMP  = 8'd75;

   typedef struct packed {
      logic                sample_valid;
      logic [TEMP_W-1:0]   temperature;
      logic [BYTES_W-1:0]  mem_used;
      logic [BYTES_W-1:0]  mem_total;
      logic                thermal_check;
      logic                memory_check;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             last_action;
   } rsp_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  critical_temp;
      logic [TEMP_W-1:0]  unload_temp;
      logic [TEMP_W-1:0]  warn_temp;
      logic [TEMP_W-1:0]  recover_temp;
      logic               gaming_guard_enable;
      logic [BYTES_W-1:0] game_free_limit;
      logic               floor_guard_enable;
      logic [BYTES_W-1:0] server_free_limit;
   } cfg_type;

   // actions of one item, in emit order, with their count
   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      logic [MAX_ACTS-1:0][ACT_W-1:0]   act;
   } bundle_type;

endpackage

`default_nettype wire

// ----- hdl/tpm_csr.sv -----
// configuration registers of the monitor
`default_nettype none

module tpm_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tpm_pkg::BYTES_W-1:0]   csr_wdata,
   output tpm_pkg::cfg_type                   cfg
);

   tpm_pkg::cfg_type cfg_ff;
   tpm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tpm_pkg::CSR_CRITICAL_TEMP: cfg_in.critical_temp = csr_wdata[tpm_pkg::TEMP_W-1:0];
            tpm_pkg::CSR_UNLOAD_TEMP:   cfg_in.unload_temp   = csr_wdata[tpm_pkg::TEMP_W-1:0];
            tpm_pkg::CSR_WARN_TEMP:     cfg_in.warn_temp     = csr_wdata[tpm_pkg::TEMP_W-1:0];
            tpm_pkg::CSR_RECOVER_TEMP:  cfg_in.recover_temp  = csr_wdata[tpm_pkg::TEMP_W-1:0];
            tpm_pkg::CSR_GAMING_ENABLE: cfg_in.gaming_guard_enable = csr_wdata[0];
            tpm_pkg::CSR_GAMING_MIN:    cfg_in.game_free_limit     = csr_wdata;
            tpm_pkg::CSR_FLOOR_ENABLE:  cfg_in.floor_guard_enable  = csr_wdata[0];
            tpm_pkg::CSR_FLOOR_MIN:     cfg_in.server_free_limit   = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.critical_temp       <= tpm_pkg::RST_CRITICAL_TEMP;
         cfg_ff.unload_temp         <= tpm_pkg::RST_UNLOAD_TEMP;
         cfg_ff.warn_temp           <= tpm_pkg::RST_WARN_TEMP;
         cfg_ff.recover_temp        <= tpm_pkg::RST_RECOVER_TEMP;
         cfg_ff.gaming_guard_enable <= 1'b0;
         cfg_ff.game_free_limit     <= '0;
         cfg_ff.floor_guard_enable  <= 1'b0;
         cfg_ff.server_free_limit   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tpm_eval.sv -----
// input register, threshold and watchdog evaluation, state flags
`default_nettype none

module tpm_eval (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tpm_pkg::req_type req_data,
   input  wire tpm_pkg::cfg_type cfg,
   input  wire logic             space_ok,
   output logic                  push,
   output tpm_pkg::bundle_type   bundle
);

   tpm_pkg::req_type item_ff;
   logic             item_valid_ff;
   logic             item_valid_in;
   logic             load;

   logic unloaded_ff, unloaded_in;
   logic warned_ff, warned_in;
   logic game_trim_done_ff, game_trim_done_in;
   logic server_trim_done_ff, server_trim_done_in;

   logic                        th_fire;
   logic [tpm_pkg::ACT_W-1:0]   th_act;
   logic                        gm_fire;
   logic                        fl_fire;
   logic [tpm_pkg::BYTES_W-1:0] free_bytes;
   logic                        gm_low;
   logic                        fl_low;
   logic                        th_on;
   logic                        mem_on;
   logic [tpm_pkg::CNT_W-1:0]   gm_pos;

   // the item in the register is evaluated once the result queue has room
   assign push          = item_valid_ff && space_ok;
   assign req_stall     = item_valid_ff && !space_ok;
   assign load          = req_valid && !req_stall;
   assign item_valid_in = load ? 1'b1 : (push ? 1'b0 : item_valid_ff);

   assign th_on  = item_ff.sample_valid && item_ff.thermal_check;
   assign mem_on = item_ff.sample_valid && item_ff.memory_check;

   // temperature hysteresis, first matching threshold wins
   always_comb begin
      th_fire     = 1'b0;
      th_act      = tpm_pkg::ACT_WARN;
      unloaded_in = unloaded_ff;
      warned_in   = warned_ff;
      if (th_on) begin
         priority if (item_ff.temperature >= cfg.critical_temp) begin
            unloaded_in = 1'b1;
            th_fire     = 1'b1;
            th_act      = tpm_pkg::ACT_CRITICAL;
         end else if (item_ff.temperature >= cfg.unload_temp) begin
            th_fire     = !unloaded_ff;
            th_act      = tpm_pkg::ACT_UNLOAD;
            unloaded_in = 1'b1;
         end else if (item_ff.temperature >= cfg.warn_temp) begin
            if (!warned_ff && !unloaded_ff) begin
               th_fire   = 1'b1;
               th_act    = tpm_pkg::ACT_WARN;
               warned_in = 1'b1;
            end
         end else if (item_ff.temperature < cfg.recover_temp) begin
            th_fire     = unloaded_ff;
            th_act      = tpm_pkg::ACT_RECOVERED;
            unloaded_in = 1'b0;
            warned_in   = 1'b0;
         end else begin
            th_fire = 1'b0;
         end
      end
   end

   // free memory clamped at zero
   assign free_bytes = (item_ff.mem_total > item_ff.mem_used) ?
                       (item_ff.mem_total - item_ff.mem_used) : '0;
   assign gm_low = free_bytes < cfg.game_free_limit;
   assign fl_low = free_bytes < cfg.server_free_limit;

   // low free memory watchdogs, each re-arms when memory recovers
   always_comb begin
      gm_fire             = 1'b0;
      fl_fire             = 1'b0;
      game_trim_done_in   = game_trim_done_ff;
      server_trim_done_in = server_trim_done_ff;
      if (mem_on && cfg.gaming_guard_enable) begin
         gm_fire           = gm_low && !game_trim_done_ff;
         game_trim_done_in = gm_low;
      end
      if (mem_on && cfg.floor_guard_enable) begin
         fl_fire             = fl_low && !server_trim_done_ff;
         server_trim_done_in = fl_low;
      end
   end

   // pack the actions in order: thermal, gaming trim, floor trim
   assign gm_pos = {1'b0, th_fire};

   always_comb begin
      bundle.count = {1'b0, th_fire} + {1'b0, gm_fire} + {1'b0, fl_fire};
      for (int k = 0; k < tpm_pkg::MAX_ACTS; k++) begin
         if (th_fire && k == 0) begin
            bundle.act[k] = th_act;
         end else if (gm_fire && gm_pos == tpm_pkg::CNT_W'(k)) begin
            bundle.act[k] = tpm_pkg::ACT_GAMING_TRIM;
         end else begin
            bundle.act[k] = tpm_pkg::ACT_FLOOR_TRIM;
         end
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

   // state flags change only when the item is evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         unloaded_ff         <= 1'b0;
         warned_ff           <= 1'b0;
         game_trim_done_ff   <= 1'b0;
         server_trim_done_ff <= 1'b0;
      end else if (push) begin
         unloaded_ff         <= unloaded_in;
         warned_ff           <= warned_in;
         game_trim_done_ff   <= game_trim_done_in;
         server_trim_done_ff <= server_trim_done_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tpm_rsp_queue.sv -----
// result queue: takes up to three actions at once, hands out one per cycle while the result side does not stall
`default_nettype none

module tpm_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tpm_pkg::bundle_type bundle,
   output logic                     space_ok,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output tpm_pkg::rsp_type         rsp_data
);

   tpm_pkg::rsp_type mem_ff [tpm_pkg::QUEUE_DEPTH];

   logic [tpm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tpm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tpm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [tpm_pkg::CNT_W-1:0]  push_count;
   logic                       pop;

   // room for a full item of three actions
   assign space_ok   = count_ff <= tpm_pkg::QCNT_W'(tpm_pkg::QUEUE_DEPTH - tpm_pkg::MAX_ACTS);
   assign push_count = push ? bundle.count : '0;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign rd_ptr_in = rd_ptr_ff + tpm_pkg::QPTR_W'(pop);
   assign wr_ptr_in = wr_ptr_ff + tpm_pkg::QPTR_W'(push_count);
   assign count_in  = count_ff + tpm_pkg::QCNT_W'(push_count) - tpm_pkg::QCNT_W'(pop);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the actions of one item, marking the final one
   always_ff @(posedge clock) begin
      for (int k = 0; k < tpm_pkg::MAX_ACTS; k++) begin
         if (tpm_pkg::CNT_W'(k) < push_count) begin
            mem_ff[wr_ptr_ff + tpm_pkg::QPTR_W'(k)].action      <= bundle.act[k];
            mem_ff[wr_ptr_ff + tpm_pkg::QPTR_W'(k)].last_action <=
               (tpm_pkg::CNT_W'(k) == push_count - 2'd1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/thermal_and_memory_pressure_monitor.sv -----
// top level of the thermal and memory pressure monitor
// path: an accepted item is held in the input register, then written to the result queue
// throughput: one item per cycle while each causes at most one result and the
//   result side keeps up; an item with n results takes n queue entries, and
//   the input stalls until three of the four entries are free
// reset: synchronous, clears the queue, the state flags and loads register defaults
`default_nettype none

module thermal_and_memory_pressure_monitor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tpm_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tpm_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tpm_pkg::BYTES_W-1:0]   csr_wdata
);

   tpm_pkg::cfg_type    cfg;
   tpm_pkg::bundle_type bundle;
   logic                push;
   logic                space_ok;

   tpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpm_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .space_ok  (space_ok),
      .push      (push),
      .bundle    (bundle)
   );

   tpm_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .bundle    (bundle),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/tpm_checker.sv -----
// port-level checks of the monitor and their binding
`default_nettype none

module tpm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tpm_pkg::rsp_type rsp_data
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the rest of an item's results follow at once, in rising action order
   a_item_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_action
         |=> rsp_valid && (rsp_data.action > $past(rsp_data.action)))
      else $error("item results not contiguous or out of order");

   // floor trim is always the final result of its item
   a_floor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.action == tpm_pkg::ACT_FLOOR_TRIM) |-> rsp_data.last_action)
      else $error("floor trim not marked final");

endmodule

bind thermal_and_memory_pressure_monitor tpm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- test/thermal_and_memory_pressure_monitor_test.sv -----
// self-checking testbench of the thermal and memory pressure monitor
module thermal_and_memory_pressure_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 500;
   localparam int PHASE_SAMPLES  = 36;
   localparam int RANDOM_PHASES  = 6;
   localparam logic [tpm_pkg::BYTES_W-1:0] BYTES_MAX = '1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   tpm_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   tpm_pkg::rsp_type              rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tpm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tpm_pkg::BYTES_W-1:0]   csr_wdata = '0;

   // shadow registers and flags of the predictor
   tpm_pkg::cfg_type settings;
   logic             hot_unloaded;
   logic             hot_warned;
   logic             game_trim_done;
   logic             server_trim_done;
   tpm_pkg::rsp_type pending_actions[$];

   // traffic shaping
   bit gaps_on = 1'b0;
   bit stall_on = 1'b0;
   int burst_left = 0;
   int stall_run = 0;

   // bookkeeping
   int errors = 0;
   int samples_sent = 0;
   int actions_checked = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   thermal_and_memory_pressure_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // one watchdog step: returns {trim fires, next trimmed flag}
   function automatic logic [1:0] trim_step(input logic enable,
                                            input logic [tpm_pkg::BYTES_W-1:0] free_bytes,
                                            input logic [tpm_pkg::BYTES_W-1:0] min_free,
                                            input logic trimmed);
      if (!enable) return {1'b0, trimmed};
      if (free_bytes < min_free) return {~trimmed, 1'b1};
      return 2'b00;
   endfunction

   // expected actions of one accepted sample, with the state update
   function automatic void predict_sample(input tpm_pkg::req_type s);
      logic [tpm_pkg::ACT_W-1:0]   acts[$];
      logic [tpm_pkg::BYTES_W-1:0] free_bytes;
      logic [1:0]                  gaming_step;
      logic [1:0]                  floor_step;
      tpm_pkg::rsp_type            r;
      if (!s.sample_valid) return;
      // thermal hysteresis, first matching threshold wins
      if (s.thermal_check) begin
         if (s.temperature >= settings.critical_temp) begin
            hot_unloaded = 1'b1;
            acts = {acts, tpm_pkg::ACT_CRITICAL};
         end else if (s.temperature >= settings.unload_temp) begin
            if (!hot_unloaded) acts = {acts, tpm_pkg::ACT_UNLOAD};
            hot_unloaded = 1'b1;
         end else if (s.temperature >= settings.warn_temp) begin
            if (!hot_warned && !hot_unloaded) begin
               acts = {acts, tpm_pkg::ACT_WARN};
               hot_warned = 1'b1;
            end
         end else if (s.temperature < settings.recover_temp) begin
            if (hot_unloaded) acts = {acts, tpm_pkg::ACT_RECOVERED};
            hot_unloaded = 1'b0;
            hot_warned = 1'b0;
         end
      end
      // low free memory watchdogs, gaming first
      if (s.memory_check) begin
         free_bytes = (s.mem_total > s.mem_used) ? s.mem_total - s.mem_used : '0;
         gaming_step = trim_step(settings.gaming_guard_enable, free_bytes,
                                 settings.game_free_limit, game_trim_done);
         floor_step = trim_step(settings.floor_guard_enable, free_bytes,
                                settings.server_free_limit, server_trim_done);
         game_trim_done = gaming_step[0];
         server_trim_done = floor_step[0];
         if (gaming_step[1]) acts = {acts, tpm_pkg::ACT_GAMING_TRIM};
         if (floor_step[1]) acts = {acts, tpm_pkg::ACT_FLOOR_TRIM};
      end
      foreach (acts[k]) begin
         r.action = acts[k];
         r.last_action = (k == acts.size() - 1);
         pending_actions = {pending_actions, r};
      end
   endfunction

   function automatic tpm_pkg::req_type make_sample(input logic valid, input int temp,
                                                    input logic [tpm_pkg::BYTES_W-1:0] used,
                                                    input logic [tpm_pkg::BYTES_W-1:0] total,
                                                    input logic thermal, input logic memory);
      tpm_pkg::req_type s;
      s.sample_valid = valid;
      s.temperature = tpm_pkg::TEMP_W'(temp);
      s.mem_used = used;
      s.mem_total = total;
      s.thermal_check = thermal;
      s.memory_check = memory;
      return s;
   endfunction

   function automatic logic [tpm_pkg::BYTES_W-1:0] rand_bytes();
      return tpm_pkg::BYTES_W'({$urandom, $urandom});
   endfunction

   // random sample, mostly close to the current thresholds
   function automatic tpm_pkg::req_type rand_sample();
      tpm_pkg::req_type            s;
      logic [tpm_pkg::BYTES_W-1:0] want_free;
      int                          t;
      s.sample_valid = ($urandom_range(0, 9) != 0);
      s.thermal_check = ($urandom_range(0, 7) != 0);
      s.memory_check = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 5))
         0: t = int'($urandom_range(0, 255));
         1: t = int'(settings.critical_temp);
         2: t = int'(settings.unload_temp);
         3: t = int'(settings.warn_temp);
         default: t = int'(settings.recover_temp);
      endcase
      t = t + int'($urandom_range(0, 4)) - 2;
      s.temperature = tpm_pkg::TEMP_W'((t < 0) ? 0 : (t > 255) ? 255 : t);
      case ($urandom_range(0, 4))
         0: begin
            s.mem_used = rand_bytes();
            s.mem_total = rand_bytes();
         end
         1: begin
            // used at or above total
            s.mem_used = rand_bytes();
            s.mem_total = s.mem_used >> $urandom_range(0, tpm_pkg::BYTES_W - 1);
         end
         default: begin
            want_free = ($urandom_range(0, 1) != 0) ? settings.game_free_limit
                                                    : settings.server_free_limit;
            want_free = want_free + tpm_pkg::BYTES_W'($urandom_range(0, 2))
                        - tpm_pkg::BYTES_W'(1);
            s.mem_total = rand_bytes();
            if (s.mem_total < want_free) s.mem_total = want_free;
            s.mem_used = s.mem_total - want_free;
         end
      endcase
      return s;
   endfunction

   function automatic tpm_pkg::cfg_type rand_settings(input int phase);
      tpm_pkg::cfg_type c;
      int               r;
      int               w;
      int               u;
      int               k;
      if (phase == 0) begin
         c = '1;
         return c;
      end
      if (phase == 1) begin
         c = '0;
         return c;
      end
      r = int'($urandom_range(0, 200));
      w = r + int'($urandom_range(0, 20));
      u = w + int'($urandom_range(0, 15));
      k = u + int'($urandom_range(0, 15));
      c.recover_temp = tpm_pkg::TEMP_W'(r);
      c.warn_temp = tpm_pkg::TEMP_W'((w > 255) ? 255 : w);
      c.unload_temp = tpm_pkg::TEMP_W'((u > 255) ? 255 : u);
      c.critical_temp = tpm_pkg::TEMP_W'((k > 255) ? 255 : k);
      // thresholds in any order now and then
      if ($urandom_range(0, 2) == 0) begin
         c.recover_temp = tpm_pkg::TEMP_W'($urandom);
         c.warn_temp = tpm_pkg::TEMP_W'($urandom);
         c.unload_temp = tpm_pkg::TEMP_W'($urandom);
         c.critical_temp = tpm_pkg::TEMP_W'($urandom);
      end
      c.gaming_guard_enable = ($urandom_range(0, 3) != 0);
      c.floor_guard_enable = ($urandom_range(0, 3) != 0);
      c.game_free_limit = ($urandom_range(0, 1) != 0) ?
                          rand_bytes() : tpm_pkg::BYTES_W'($urandom_range(0, 1 << 20));
      c.server_free_limit = ($urandom_range(0, 1) != 0) ?
                            rand_bytes() : tpm_pkg::BYTES_W'($urandom_range(0, 1 << 20));
      return c;
   endfunction

   // wait until every expected action is out and the block has settled
   task automatic quiesce();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write every register, in index order, while the block is idle
   task automatic load_settings(input tpm_pkg::cfg_type c);
      logic [tpm_pkg::BYTES_W-1:0] values[8];
      quiesce();
      values[tpm_pkg::CSR_CRITICAL_TEMP] = tpm_pkg::BYTES_W'(c.critical_temp);
      values[tpm_pkg::CSR_UNLOAD_TEMP] = tpm_pkg::BYTES_W'(c.unload_temp);
      values[tpm_pkg::CSR_WARN_TEMP] = tpm_pkg::BYTES_W'(c.warn_temp);
      values[tpm_pkg::CSR_RECOVER_TEMP] = tpm_pkg::BYTES_W'(c.recover_temp);
      values[tpm_pkg::CSR_GAMING_ENABLE] = tpm_pkg::BYTES_W'(c.gaming_guard_enable);
      values[tpm_pkg::CSR_GAMING_MIN] = c.game_free_limit;
      values[tpm_pkg::CSR_FLOOR_ENABLE] = tpm_pkg::BYTES_W'(c.floor_guard_enable);
      values[tpm_pkg::CSR_FLOOR_MIN] = c.server_free_limit;
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= tpm_pkg::CSR_IDX_W'(i);
         csr_wdata <= values[i];
         do @(posedge clock); while (!csr_ready);
         csr_writes++;
      end
      csr_valid <= 1'b0;
      settings = c;
   endtask

   // send one item; with gaps on, items go in bursts separated by random gaps
   task automatic send_sample(input tpm_pkg::req_type s);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall);
      predict_sample(s);
      if (burst_left > 0) burst_left--;
      if (s.sample_valid) samples_sent++;
   endtask

   // walk the default thresholds up and down
   task automatic test_thermal_hysteresis();
      gaps_on = 1'b1;
      stall_on = 1'b1;
      send_sample(make_sample(1'b1, 80, BYTES_MAX, '0, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 85, '0, BYTES_MAX, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 89, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 90, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 92, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 95, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 255, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b0, 0, BYTES_MAX, BYTES_MAX, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 0, '0, '0, 1'b0, 1'b0));
      send_sample(make_sample(1'b1, 74, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 0, '0, '0, 1'b1, 1'b0));
      send_sample(make_sample(1'b1, 86, '0, '0, 1'b1, 1'b0));
   endtask

   // both watchdogs firing, holding and re-arming
   task automatic test_memory_watchdogs();
      tpm_pkg::cfg_type c;
      c = settings;
      c.gaming_guard_enable = 1'b1;
      c.game_free_limit = 48'd1000;
      c.floor_guard_enable = 1'b1;
      c.server_free_limit = BYTES_MAX;
      load_settings(c);
      send_sample(make_sample(1'b1, 255, BYTES_MAX, '0, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 255, BYTES_MAX, '0, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 80, '0, BYTES_MAX, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 80, 48'd1000, 48'd1999, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 80, 48'd1000, 48'd2000, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 80, BYTES_MAX, '0, 1'b1, 1'b0));
   endtask

   // thresholds at the extremes and out of order, one watchdog disabled
   task automatic test_threshold_order();
      tpm_pkg::cfg_type c;
      c = settings;
      c.critical_temp = '0;
      c.gaming_guard_enable = 1'b0;
      load_settings(c);
      send_sample(make_sample(1'b1, 0, BYTES_MAX, '0, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 0, '0, BYTES_MAX, 1'b1, 1'b1));
      c.critical_temp = '1;
      c.unload_temp = '0;
      c.warn_temp = '1;
      c.recover_temp = '1;
      c.gaming_guard_enable = 1'b1;
      load_settings(c);
      send_sample(make_sample(1'b1, 254, 48'd5, 48'd5, 1'b1, 1'b1));
      send_sample(make_sample(1'b1, 255, 48'd5, 48'd5, 1'b1, 1'b1));
   endtask

   // random samples over several random settings
   task automatic test_random_traffic();
      int               sent_at_start;
      tpm_pkg::req_type s;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_settings(rand_settings(phase));
         gaps_on = (phase != 2);
         stall_on = (phase != 2);
         sent_at_start = samples_sent;
         while (samples_sent - sent_at_start < PHASE_SAMPLES) begin
            s = rand_sample();
            send_sample(s);
         end
      end
   endtask

   // response stall pattern: runs of stall and free cycles of random length
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         rsp_stall <= ~rsp_stall;
         stall_run <= rsp_stall ? $urandom_range(1, 9) : $urandom_range(0, 4);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // compare each accepted result with the oldest expected action
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_actions.size() == 0) begin
            $display("%0t: action expected none actual %0d last %0b", $time,
                     rsp_data.action, rsp_data.last_action);
            errors++;
         end else begin
            if (rsp_data.action !== pending_actions[0].action) begin
               $display("%0t: action expected %0d actual %0d", $time,
                        pending_actions[0].action, rsp_data.action);
               errors++;
            end
            if (rsp_data.last_action !== pending_actions[0].last_action) begin
               $display("%0t: last_action expected %0b actual %0b", $time,
                        pending_actions[0].last_action, rsp_data.last_action);
               errors++;
            end
            void'(pending_actions.pop_front());
            actions_checked++;
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d actions outstanding", $time,
                  QUIET_LIMIT, pending_actions.size());
         $display("thermal_and_memory_pressure_monitor regression: fail");
         $finish;
      end
   end

   // test sequence
   initial begin
      settings = '0;
      settings.critical_temp = tpm_pkg::RST_CRITICAL_TEMP;
      settings.unload_temp = tpm_pkg::RST_UNLOAD_TEMP;
      settings.warn_temp = tpm_pkg::RST_WARN_TEMP;
      settings.recover_temp = tpm_pkg::RST_RECOVER_TEMP;
      hot_unloaded = 1'b0;
      hot_warned = 1'b0;
      game_trim_done = 1'b0;
      server_trim_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_thermal_hysteresis();
      test_memory_watchdogs();
      test_threshold_order();
      test_random_traffic();
      quiesce();
      $display("covered %0d valid samples and %0d checked actions", samples_sent,
               actions_checked);
      $display("with %0d register writes across %0d settings", csr_writes, csr_writes / 8);
      if (errors == 0)
         $display("thermal_and_memory_pressure_monitor regression: pass");
      else
         $display("thermal_and_memory_pressure_monitor regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/tpm_pkg.sv
hdl/tpm_csr.sv
hdl/tpm_eval.sv
hdl/tpm_rsp_queue.sv
hdl/thermal_and_memory_pressure_monitor.sv
hdl/tpm_checker.sv
test/thermal_and_memory_pressure_monitor_test.sv
